// File: rtl/core/trapmp_pkg.sv
// Shared constants, widths and command codes of the trapezoid motion profile block.
package trapmp_pkg;

    localparam int SCALE_FRAC_BITS = 15;
    localparam int POS_FRAC_BITS   = 18;
    localparam int Q10_BITS        = 10;
    localparam int Q10_SHIFT       = POS_FRAC_BITS - Q10_BITS;

    localparam int POS_W    = 32;
    localparam int LIMIT_W  = 31;
    localparam int SPEED_W  = 32;
    localparam int TOTAL_W  = POS_W + POS_FRAC_BITS;
    localparam int DIST_W   = TOTAL_W + 2;
    localparam int DIFF_W   = DIST_W + 1;
    localparam int WHOLE_W  = DIST_W - POS_FRAC_BITS;

    localparam int SNAP_TICKS  = 15;
    localparam int SNAP_Q      = SNAP_TICKS << POS_FRAC_BITS;
    localparam int REMAIN_SAT  = 309244;
    localparam int REM_W       = 29;
    localparam int REM_SAT_Q10 = REMAIN_SAT << Q10_BITS;

    // speed^2 term: (2*speed >> Q10_SHIFT) * (speed >> Q10_SHIFT)
    localparam int SQA_W      = SPEED_W - Q10_SHIFT;
    localparam int SQB_W      = SPEED_W - 1 - Q10_SHIFT;
    localparam int SQ_PROD_W  = SQA_W + SQB_W;
    // braking term: (2*remaining) * (decel >> Q10_SHIFT)
    localparam int DECB_W     = LIMIT_W - Q10_SHIFT;
    localparam int BRK_PROD_W = REM_W + 1 + DECB_W;
    localparam int CMP_W      = BRK_PROD_W - Q10_BITS;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_ABORT = 2'd3
    } cmd_t;

endpackage

// File: rtl/core/trapezoid_motion_profile.sv
// Trapezoid motion profile generator: item register, single-pass update, result register.
// A tick item's result is registered in the result register and presented on out_valid.
// Throughput: one item per cycle unless out_ready stalls; a tick's update is one pass through two
// narrow multipliers and the speed/distance adders between the item and result registers.
// Reset: rst_n clears limits, flags, speed, distances and the origin to zero at once (not the result data).
module trapezoid_motion_profile #(
    parameter int SCALE_FRAC_BITS = trapmp_pkg::SCALE_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [trapmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [trapmp_pkg::LIMIT_W-1:0]       cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           cmd,
    input  logic signed [trapmp_pkg::POS_W-1:0]  measured_position,
    input  logic signed [trapmp_pkg::POS_W-1:0]  move_distance,
    input  logic [SCALE_FRAC_BITS-1:0]           accel_fraction,
    input  logic [SCALE_FRAC_BITS-1:0]           decel_fraction,
    input  logic [SCALE_FRAC_BITS-1:0]           speed_fraction,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [trapmp_pkg::POS_W-1:0]  commanded_position,
    output logic                                 moving
);

    localparam int PosW    = trapmp_pkg::POS_W;
    localparam int LimitW  = trapmp_pkg::LIMIT_W;
    localparam int SpeedW  = trapmp_pkg::SPEED_W;
    localparam int TotalW  = trapmp_pkg::TOTAL_W;
    localparam int DistW   = trapmp_pkg::DIST_W;
    localparam int DiffW   = trapmp_pkg::DIFF_W;
    localparam int WholeW  = trapmp_pkg::WHOLE_W;
    localparam int FracQ   = trapmp_pkg::POS_FRAC_BITS;
    localparam int ShQ10   = trapmp_pkg::Q10_SHIFT;
    localparam int BitsQ10 = trapmp_pkg::Q10_BITS;
    localparam int RemW    = trapmp_pkg::REM_W;
    localparam int SqaW    = trapmp_pkg::SQA_W;
    localparam int SqbW    = trapmp_pkg::SQB_W;
    localparam int SqProdW = trapmp_pkg::SQ_PROD_W;
    localparam int BrkW    = trapmp_pkg::BRK_PROD_W;
    localparam int CmpW    = trapmp_pkg::CMP_W;
    localparam int ProdW   = SCALE_FRAC_BITS + LimitW;

    // configuration
    logic [LimitW-1:0] accel_limit_reg;
    logic [LimitW-1:0] decel_limit_reg;
    logic [LimitW-1:0] speed_limit_reg;

    // item register
    logic                      item_vld_reg;
    trapmp_pkg::cmd_t          item_cmd_reg;
    logic [PosW-1:0]           item_meas_reg;
    logic [PosW-1:0]           item_dist_reg;
    logic [SCALE_FRAC_BITS-1:0] item_afrac_reg;
    logic [SCALE_FRAC_BITS-1:0] item_dfrac_reg;
    logic [SCALE_FRAC_BITS-1:0] item_sfrac_reg;

    // profile state
    logic              busy_reg, busy_next;
    logic              start_pend_reg, start_pend_next;
    logic              stop_pend_reg, stop_pend_next;
    logic              reverse_reg, reverse_next;
    logic [DistW-1:0]  dist_left_reg, dist_left_next;
    logic [TotalW-1:0] dist_total_reg, dist_total_next;
    logic [PosW-1:0]   origin_reg, origin_next;
    logic [SpeedW-1:0] speed_reg, speed_next;
    logic [LimitW-1:0] move_accel_reg, move_accel_next;
    logic [LimitW-1:0] move_decel_reg, move_decel_next;
    logic [LimitW-1:0] move_speed_reg, move_speed_next;

    // result register
    logic              out_vld_reg, out_vld_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic              moving_reg, moving_next;

    logic              fire;

    // move command datapath
    logic [ProdW-1:0]  accel_prod, decel_prod, speed_prod;
    logic [PosW-1:0]   dist_mag;

    // tick datapath
    logic [SpeedW:0]   spd_ext, spd_dec, spd_acc;
    logic              dl_le0, snap_hit, rem_sat, brake;
    logic [SqaW-1:0]   sq_a;
    logic [SqbW-1:0]   sq_b;
    logic [SqProdW-1:0] sq_prod;
    logic [RemW-1:0]   rem_q10;
    logic [BrkW-1:0]   brk_prod;
    logic [SpeedW-1:0] tick_speed;
    logic              tick_busy, tick_stop, tick_meas;
    logic [DistW-1:0]  tick_dl_sel, tick_dl;
    logic [PosW-1:0]   tick_origin, trav, trav_dir, tick_pos;
    logic [DiffW-1:0]  diff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_limit_reg <= '0;
            decel_limit_reg <= '0;
            speed_limit_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                trapmp_pkg::REG_ACCEL_LIMIT: accel_limit_reg <= cfg_data;
                trapmp_pkg::REG_DECEL_LIMIT: decel_limit_reg <= cfg_data;
                trapmp_pkg::REG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // hand-off: the item register drains whenever the result slot is free or freeing
    assign fire     = item_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !item_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            item_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_cmd_reg   <= trapmp_pkg::cmd_t'(cmd);
            item_meas_reg  <= measured_position;
            item_dist_reg  <= move_distance;
            item_afrac_reg <= accel_fraction;
            item_dfrac_reg <= decel_fraction;
            item_sfrac_reg <= speed_fraction;
        end
    end

    // scale limits by the move fractions
    assign accel_prod = ProdW'(item_afrac_reg) * ProdW'(accel_limit_reg);
    assign decel_prod = ProdW'(item_dfrac_reg) * ProdW'(decel_limit_reg);
    assign speed_prod = ProdW'(item_sfrac_reg) * ProdW'(speed_limit_reg);
    assign dist_mag   = item_dist_reg[PosW-1] ? PosW'(-item_dist_reg) : item_dist_reg;

    // speed arithmetic, one bit wider than the speed register
    assign spd_ext = {speed_reg[SpeedW-1], speed_reg};
    assign spd_dec = spd_ext - {2'b00, move_decel_reg};
    assign spd_acc = spd_ext + {2'b00, move_accel_reg};

    assign dl_le0   = dist_left_reg[DistW-1] || (dist_left_reg == '0);
    assign snap_hit = (dist_left_reg < DistW'(trapmp_pkg::SNAP_Q))
                   && (dist_left_reg < DistW'(move_decel_reg));

    // braking test in Q10: 2*remaining*decel <= 2*speed^2
    assign sq_a     = speed_reg[SpeedW-2:ShQ10-1];
    assign sq_b     = speed_reg[SpeedW-2:ShQ10];
    assign sq_prod  = SqProdW'(sq_a) * SqProdW'(sq_b);
    assign rem_sat  = dist_left_reg[DistW-1:FracQ] > WholeW'(trapmp_pkg::REMAIN_SAT);
    assign rem_q10  = rem_sat ? RemW'(trapmp_pkg::REM_SAT_Q10)
                              : dist_left_reg[RemW+ShQ10-1:ShQ10];
    assign brk_prod = BrkW'({rem_q10, 1'b0}) * BrkW'(move_decel_reg[LimitW-1:ShQ10]);
    assign brake    = brk_prod[BrkW-1:BitsQ10] <= CmpW'(sq_prod[SqProdW-1:BitsQ10]);

    always_comb
    begin
        tick_speed  = speed_reg;
        tick_busy   = busy_reg;
        tick_stop   = stop_pend_reg;
        tick_meas   = 1'b0;
        tick_dl_sel = dist_left_reg;
        if (stop_pend_reg)
        begin
            if (dl_le0 || spd_dec[SpeedW])
            begin
                tick_speed = '0;
                tick_busy  = 1'b0;
                tick_stop  = 1'b0;
                tick_meas  = 1'b1;
            end
            else
            begin
                tick_speed = spd_dec[SpeedW-1:0];
            end
        end
        else if (dl_le0 || speed_reg[SpeedW-1])
        begin
            tick_speed  = '0;
            tick_busy   = 1'b0;
            tick_stop   = 1'b0;
            tick_dl_sel = '0;
        end
        else if (snap_hit)
        begin
            tick_speed  = SpeedW'(dist_left_reg);
            tick_dl_sel = '0;
        end
        else if (brake)
        begin
            tick_speed = spd_dec[SpeedW-1:0];
        end
        else if (spd_acc > {2'b00, move_speed_reg})
        begin
            tick_speed = {1'b0, move_speed_reg};
        end
        else
        begin
            tick_speed = spd_acc[SpeedW-1:0];
        end
    end

    assign tick_dl     = tick_dl_sel - {{(DistW-SpeedW){tick_speed[SpeedW-1]}}, tick_speed};
    assign tick_origin = start_pend_reg ? item_meas_reg : origin_reg;
    assign diff        = DiffW'(dist_total_reg) - {tick_dl[DistW-1], tick_dl};
    assign trav        = diff[FracQ+PosW-1:FracQ];
    assign trav_dir    = reverse_reg ? PosW'(-trav) : trav;
    assign tick_pos    = tick_origin + trav_dir;

    always_comb
    begin
        busy_next       = busy_reg;
        start_pend_next = start_pend_reg;
        stop_pend_next  = stop_pend_reg;
        reverse_next    = reverse_reg;
        dist_left_next  = dist_left_reg;
        dist_total_next = dist_total_reg;
        origin_next     = origin_reg;
        speed_next      = speed_reg;
        move_accel_next = move_accel_reg;
        move_decel_next = move_decel_reg;
        move_speed_next = move_speed_reg;
        pos_next        = pos_reg;
        moving_next     = moving_reg;
        out_vld_next    = out_vld_reg && !out_ready;
        if (fire)
        begin
            unique case (item_cmd_reg)
                trapmp_pkg::CMD_MOVE:
                begin
                    move_accel_next = accel_prod[ProdW-1:SCALE_FRAC_BITS];
                    move_decel_next = decel_prod[ProdW-1:SCALE_FRAC_BITS];
                    move_speed_next = speed_prod[ProdW-1:SCALE_FRAC_BITS];
                    reverse_next    = item_dist_reg[PosW-1];
                    dist_left_next  = DistW'({dist_mag, {FracQ{1'b0}}});
                    dist_total_next = {dist_mag, {FracQ{1'b0}}};
                    speed_next      = busy_reg ? speed_reg : '0;
                    busy_next       = 1'b1;
                    start_pend_next = 1'b1;
                    stop_pend_next  = 1'b0;
                end
                trapmp_pkg::CMD_STOP:
                begin
                    stop_pend_next = 1'b1;
                end
                trapmp_pkg::CMD_ABORT:
                begin
                    speed_next      = '0;
                    busy_next       = 1'b0;
                    start_pend_next = 1'b0;
                end
                trapmp_pkg::CMD_TICK:
                begin
                    out_vld_next = 1'b1;
                    if (!busy_reg)
                    begin
                        pos_next    = item_meas_reg;
                        moving_next = 1'b0;
                    end
                    else
                    begin
                        start_pend_next = 1'b0;
                        origin_next     = tick_origin;
                        speed_next      = tick_speed;
                        busy_next       = tick_busy;
                        stop_pend_next  = tick_stop;
                        if (tick_meas)
                        begin
                            pos_next    = item_meas_reg;
                            moving_next = 1'b0;
                        end
                        else
                        begin
                            dist_left_next = tick_dl;
                            pos_next       = tick_pos;
                            moving_next    = tick_busy;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            start_pend_reg <= 1'b0;
            stop_pend_reg  <= 1'b0;
            reverse_reg    <= 1'b0;
            dist_left_reg  <= '0;
            dist_total_reg <= '0;
            origin_reg     <= '0;
            speed_reg      <= '0;
            move_accel_reg <= '0;
            move_decel_reg <= '0;
            move_speed_reg <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            start_pend_reg <= start_pend_next;
            stop_pend_reg  <= stop_pend_next;
            reverse_reg    <= reverse_next;
            dist_left_reg  <= dist_left_next;
            dist_total_reg <= dist_total_next;
            origin_reg     <= origin_next;
            speed_reg      <= speed_next;
            move_accel_reg <= move_accel_next;
            move_decel_reg <= move_decel_next;
            move_speed_reg <= move_speed_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        moving_reg <= moving_next;
    end

    assign out_valid          = out_vld_reg;
    assign commanded_position = pos_reg;
    assign moving             = moving_reg;

`ifndef ASSERT_OFF
    a_start_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_pend_reg |-> busy_reg)
        else $error("start pending without an active move");

    a_idle_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (speed_reg == '0))
        else $error("nonzero speed while idle");

    a_result_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item_cmd_reg != trapmp_pkg::CMD_TICK)) |=> !out_vld_reg)
        else $error("result produced by a non-tick item");
`endif

endmodule
